// ===== sv/c2s_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_pkg: shared types and constants of the Cartesian-to-spherical converter
// Beat types of both channels, the item types that travel along the root and
// CORDIC cell rows, and the arctangent constants in Q60.
// ----------------------------------------------------------------------------
package c2s_pkg;

   // field widths and number formats
   localparam int COORD_WIDTH       = 32;
   localparam int ANGLE_FRAC_BITS   = 29;
   localparam int CORDIC_STAGES_DEF = 32;
   localparam int RADIUS_WIDTH      = 32;
   localparam int AZIMUTH_WIDTH     = 32;
   localparam int POLAR_WIDTH       = 31;

   // square root datapath
   localparam int ROOT_WIDTH     = COORD_WIDTH;
   localparam int RADICAND_WIDTH = 2 * COORD_WIDTH;
   localparam int REM_WIDTH      = ROOT_WIDTH + 2;

   // CORDIC datapath: operand scaled by 2^GUARD_BITS plus headroom for gain
   localparam int GUARD_BITS    = 24;
   localparam int EXT_BITS      = 4;
   localparam int CORDIC_WIDTH  = COORD_WIDTH + GUARD_BITS + EXT_BITS;
   localparam int ANG_WIDTH     = 64;
   localparam int ANG_ACC_FRAC  = 60;
   localparam int ANG_SHIFT     = ANG_ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int ANG_OUT_WIDTH = ANG_WIDTH - ANG_SHIFT;

   localparam logic [ANG_WIDTH-1:0] ONE_Q60  = 64'd1 << ANG_ACC_FRAC;
   localparam logic [ANG_WIDTH-1:0] ANG_HALF = 64'd1 << (ANG_SHIFT - 1);

   // input beat
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x_coord;
      logic signed [COORD_WIDTH-1:0] y_coord;
      logic signed [COORD_WIDTH-1:0] z_coord;
   } c2s_req_type;

   // result beat
   typedef struct packed {
      logic        [RADIUS_WIDTH-1:0]  radius;
      logic signed [AZIMUTH_WIDTH-1:0] azimuth;
      logic        [POLAR_WIDTH-1:0]   polar_angle;
   } c2s_rsp_type;

   // one square root in progress: remaining radicand bits, root, remainder
   typedef struct packed {
      logic [RADICAND_WIDTH-1:0] bits;
      logic [ROOT_WIDTH-1:0]     root;
      logic [REM_WIDTH-1:0]      rem;
   } c2s_root_lane_type;

   typedef struct packed {
      c2s_root_lane_type rho;
      c2s_root_lane_type rad;
      c2s_req_type       vec;
   } c2s_root_item_type;

   // one vectoring CORDIC in progress
   typedef struct packed {
      logic signed [CORDIC_WIDTH-1:0] x;
      logic signed [CORDIC_WIDTH-1:0] y;
      logic signed [ANG_WIDTH-1:0]    ang;
   } c2s_cordic_lane_type;

   typedef struct packed {
      c2s_cordic_lane_type     az;
      c2s_cordic_lane_type     pol;
      logic [RADIUS_WIDTH-1:0] radius;
      logic                    az_zero;
      logic                    all_zero;
   } c2s_cordic_item_type;

   // atan(2^-idx) in Q60 by the truncated series t - t^3/3 + t^5/5 - ...
   function automatic logic [ANG_WIDTH-1:0] atan_pow2_q60(input int unsigned idx);
      logic [ANG_WIDTH-1:0] acc;
      acc = '0;
      acc = acc + ((ONE_Q60 >> (idx * 1))  / 64'd1);
      acc = acc - ((ONE_Q60 >> (idx * 3))  / 64'd3);
      acc = acc + ((ONE_Q60 >> (idx * 5))  / 64'd5);
      acc = acc - ((ONE_Q60 >> (idx * 7))  / 64'd7);
      acc = acc + ((ONE_Q60 >> (idx * 9))  / 64'd9);
      acc = acc - ((ONE_Q60 >> (idx * 11)) / 64'd11);
      acc = acc + ((ONE_Q60 >> (idx * 13)) / 64'd13);
      acc = acc - ((ONE_Q60 >> (idx * 15)) / 64'd15);
      acc = acc + ((ONE_Q60 >> (idx * 17)) / 64'd17);
      acc = acc - ((ONE_Q60 >> (idx * 19)) / 64'd19);
      acc = acc + ((ONE_Q60 >> (idx * 21)) / 64'd21);
      acc = acc - ((ONE_Q60 >> (idx * 23)) / 64'd23);
      acc = acc + ((ONE_Q60 >> (idx * 25)) / 64'd25);
      acc = acc - ((ONE_Q60 >> (idx * 27)) / 64'd27);
      acc = acc + ((ONE_Q60 >> (idx * 29)) / 64'd29);
      acc = acc - ((ONE_Q60 >> (idx * 31)) / 64'd31);
      acc = acc + ((ONE_Q60 >> (idx * 33)) / 64'd33);
      acc = acc - ((ONE_Q60 >> (idx * 35)) / 64'd35);
      acc = acc + ((ONE_Q60 >> (idx * 37)) / 64'd37);
      acc = acc - ((ONE_Q60 >> (idx * 39)) / 64'd39);
      acc = acc + ((ONE_Q60 >> (idx * 41)) / 64'd41);
      acc = acc - ((ONE_Q60 >> (idx * 43)) / 64'd43);
      acc = acc + ((ONE_Q60 >> (idx * 45)) / 64'd45);
      acc = acc - ((ONE_Q60 >> (idx * 47)) / 64'd47);
      acc = acc + ((ONE_Q60 >> (idx * 49)) / 64'd49);
      acc = acc - ((ONE_Q60 >> (idx * 51)) / 64'd51);
      acc = acc + ((ONE_Q60 >> (idx * 53)) / 64'd53);
      acc = acc - ((ONE_Q60 >> (idx * 55)) / 64'd55);
      acc = acc + ((ONE_Q60 >> (idx * 57)) / 64'd57);
      acc = acc - ((ONE_Q60 >> (idx * 59)) / 64'd59);
      return acc;
   endfunction

   // atan(1/3) in Q60 by the same series, down to the term with 3^37
   localparam logic [ANG_WIDTH-1:0] ATAN_THIRD_Q60 =
        ((ONE_Q60 / (64'd3 ** 1))  / 64'd1)
      - ((ONE_Q60 / (64'd3 ** 3))  / 64'd3)
      + ((ONE_Q60 / (64'd3 ** 5))  / 64'd5)
      - ((ONE_Q60 / (64'd3 ** 7))  / 64'd7)
      + ((ONE_Q60 / (64'd3 ** 9))  / 64'd9)
      - ((ONE_Q60 / (64'd3 ** 11)) / 64'd11)
      + ((ONE_Q60 / (64'd3 ** 13)) / 64'd13)
      - ((ONE_Q60 / (64'd3 ** 15)) / 64'd15)
      + ((ONE_Q60 / (64'd3 ** 17)) / 64'd17)
      - ((ONE_Q60 / (64'd3 ** 19)) / 64'd19)
      + ((ONE_Q60 / (64'd3 ** 21)) / 64'd21)
      - ((ONE_Q60 / (64'd3 ** 23)) / 64'd23)
      + ((ONE_Q60 / (64'd3 ** 25)) / 64'd25)
      - ((ONE_Q60 / (64'd3 ** 27)) / 64'd27)
      + ((ONE_Q60 / (64'd3 ** 29)) / 64'd29)
      - ((ONE_Q60 / (64'd3 ** 31)) / 64'd31)
      + ((ONE_Q60 / (64'd3 ** 33)) / 64'd33)
      - ((ONE_Q60 / (64'd3 ** 35)) / 64'd35)
      + ((ONE_Q60 / (64'd3 ** 37)) / 64'd37);

   // CORDIC step angle; atan(1) is built as atan(1/2) + atan(1/3)
   function automatic logic [ANG_WIDTH-1:0] atan_q60(input int unsigned idx);
      logic [ANG_WIDTH-1:0] val;
      if (idx == 0) begin
         val = atan_pow2_q60(1) + ATAN_THIRD_Q60;
      end else begin
         val = atan_pow2_q60(idx);
      end
      return val;
   endfunction

   localparam logic [ANG_WIDTH-1:0] PI_Q60      = atan_q60(0) << 2;
   localparam logic [ANG_WIDTH-1:0] PI_OUT_FULL = (PI_Q60 + ANG_HALF) >> ANG_SHIFT;
   localparam logic signed [ANG_OUT_WIDTH-1:0] PI_OUT = PI_OUT_FULL[ANG_OUT_WIDTH-1:0];

endpackage
`default_nettype wire

// ===== sv/c2s_root_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_root_cell: one bit of the two square roots
// Restoring digit-by-digit step for the horizontal and the full magnitude;
// the vector rides along for the CORDIC cells further down the row.
// ----------------------------------------------------------------------------
module c2s_root_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  c2s_pkg::c2s_root_item_type in_item,
   output logic                       out_valid,
   output c2s_pkg::c2s_root_item_type out_item
);
   import c2s_pkg::*;

   // bring down two radicand bits, try to subtract 4q+1
   function automatic c2s_root_lane_type root_step(input c2s_root_lane_type lane);
      logic [1:0]           pair;
      logic [REM_WIDTH+1:0] trial;
      c2s_root_lane_type    nxt;
      pair     = lane.bits[RADICAND_WIDTH-1 -: 2];
      trial    = {lane.rem, pair} - {2'b00, lane.root, 2'b01};
      nxt.bits = {lane.bits[RADICAND_WIDTH-3:0], 2'b00};
      if (!trial[REM_WIDTH+1]) begin
         nxt.rem  = trial[REM_WIDTH-1:0];
         nxt.root = {lane.root[ROOT_WIDTH-2:0], 1'b1};
      end else begin
         nxt.rem  = {lane.rem[REM_WIDTH-3:0], pair};
         nxt.root = {lane.root[ROOT_WIDTH-2:0], 1'b0};
      end
      return nxt;
   endfunction

   logic              valid_ff;
   c2s_root_item_type item_ff;
   c2s_root_item_type item_in;

   // step both lanes
   always_comb begin
      item_in     = in_item;
      item_in.rho = root_step(in_item.rho);
      item_in.rad = root_step(in_item.rad);
   end

   // cell register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

// ===== sv/c2s_cordic_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates the azimuth and the polar vector by +-atan(2^-STAGE_IDX) toward
// the x axis and accumulates the angle in Q60.
// ----------------------------------------------------------------------------
module c2s_cordic_cell #(
   parameter int STAGE_IDX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  c2s_pkg::c2s_cordic_item_type in_item,
   output logic                         out_valid,
   output c2s_pkg::c2s_cordic_item_type out_item
);
   import c2s_pkg::*;

   localparam logic [ANG_WIDTH-1:0] ATAN_STEP = atan_q60(STAGE_IDX);

   // rotate one lane so that y heads toward zero
   function automatic c2s_cordic_lane_type rotate(input c2s_cordic_lane_type lane);
      logic signed [CORDIC_WIDTH-1:0] xs;
      logic signed [CORDIC_WIDTH-1:0] ys;
      c2s_cordic_lane_type            nxt;
      xs = lane.x >>> STAGE_IDX;
      ys = lane.y >>> STAGE_IDX;
      if (!lane.y[CORDIC_WIDTH-1]) begin
         nxt.x   = lane.x + ys;
         nxt.y   = lane.y - xs;
         nxt.ang = lane.ang + ATAN_STEP;
      end else begin
         nxt.x   = lane.x - ys;
         nxt.y   = lane.y + xs;
         nxt.ang = lane.ang - ATAN_STEP;
      end
      return nxt;
   endfunction

   logic                valid_ff;
   c2s_cordic_item_type item_ff;
   c2s_cordic_item_type item_in;

   // both lanes step together
   always_comb begin
      item_in     = in_item;
      item_in.az  = rotate(in_item.az);
      item_in.pol = rotate(in_item.pol);
   end

   // cell register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

// ===== sv/cartesian_to_spherical.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cartesian_to_spherical: Q16.16 vector to radius, azimuth and polar angle
// Squares, two rows of cells (square root, then CORDIC) and a rounding and
// clamping stage, followed by an output register with a one-beat skid.
// ----------------------------------------------------------------------------
// The block takes one vector per clock while req_ready is high and returns
// one result beat per vector, in order. An accepted request beat passes
// through the squaring register, the summing register, 32 square root
// cells (one root bit each), the rounding register, the pre-rotation
// register, CORDIC_STAGES rotation cells and the output register before
// it shows on rsp_valid. The radius is the rounded integer square root of
// x^2+y^2+z^2; the azimuth is atan2(y,x) and the polar angle is
// atan2(sqrt(x^2+y^2), z), in signed Q3.29 and unsigned Q2.29 radians,
// clamped to [-pi, pi] and [0, pi]. A zero vector gives all zeros and
// x = y = 0 gives a zero azimuth. The whole row moves as one; it stops
// only while the output register and its skid beat both hold results, and
// req_ready is the inverse of the skid flop.
// ----------------------------------------------------------------------------
module cartesian_to_spherical #(
   parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  c2s_pkg::c2s_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output c2s_pkg::c2s_rsp_type rsp_data
);
   import c2s_pkg::*;

   // magnitude of a signed coordinate
   function automatic logic [COORD_WIDTH-1:0] mag(input logic signed [COORD_WIDTH-1:0] v);
      logic [COORD_WIDTH-1:0] m;
      m = v[COORD_WIDTH-1] ? (~v + COORD_WIDTH'(1)) : v;
      return m;
   endfunction

   // Q60 angle to output scale, rounded half up
   function automatic logic signed [ANG_OUT_WIDTH-1:0] to_out(
      input logic signed [ANG_WIDTH-1:0] ang
   );
      logic [ANG_WIDTH-1:0] sum;
      sum = ang + ANG_HALF;
      return sum[ANG_WIDTH-1:ANG_SHIFT];
   endfunction

   logic enable;

   // square stage
   logic                      sq_valid_ff;
   c2s_req_type               sq_vec_ff;
   logic [RADICAND_WIDTH-1:0] sq_px_ff;
   logic [RADICAND_WIDTH-1:0] sq_py_ff;
   logic [RADICAND_WIDTH-1:0] sq_pz_ff;
   logic [COORD_WIDTH-1:0]    mag_x;
   logic [COORD_WIDTH-1:0]    mag_y;
   logic [COORD_WIDTH-1:0]    mag_z;
   logic [RADICAND_WIDTH-1:0] sq_px_in;
   logic [RADICAND_WIDTH-1:0] sq_py_in;
   logic [RADICAND_WIDTH-1:0] sq_pz_in;

   // sum stage feeds the root row
   logic              sum_valid_ff;
   c2s_root_item_type sum_item_ff;
   c2s_root_item_type sum_item_in;
   logic [RADICAND_WIDTH-1:0] sum_xy;

   logic              root_valid [ROOT_WIDTH+1];
   c2s_root_item_type root_item  [ROOT_WIDTH+1];

   // rounding stage
   logic                   rnd_valid_ff;
   logic [ROOT_WIDTH-1:0]  rnd_rho_ff;
   logic [ROOT_WIDTH-1:0]  rnd_rad_ff;
   c2s_req_type            rnd_vec_ff;
   logic [ROOT_WIDTH-1:0]  rnd_rho_in;
   logic [ROOT_WIDTH-1:0]  rnd_rad_in;
   c2s_root_item_type      root_last;

   // pre-rotation stage feeds the CORDIC row
   logic                pre_valid_ff;
   c2s_cordic_item_type pre_item_ff;
   c2s_cordic_item_type pre_item_in;

   logic                cordic_valid [CORDIC_STAGES+1];
   c2s_cordic_item_type cordic_item  [CORDIC_STAGES+1];

   // finish and output
   c2s_cordic_item_type              fin_item;
   logic                             fin_valid;
   c2s_rsp_type                      fin_rsp;
   logic signed [ANG_OUT_WIDTH-1:0]  fin_az;
   logic signed [ANG_OUT_WIDTH-1:0]  fin_pol;
   logic                             out_take;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   c2s_rsp_type                      rsp_data_ff;
   c2s_rsp_type                      rsp_data_in;
   logic                             skid_valid_ff;
   logic                             skid_valid_in;
   c2s_rsp_type                      skid_data_ff;
   c2s_rsp_type                      skid_data_in;

   // row advances unless the skid beat is occupied
   assign enable    = !skid_valid_ff;
   assign req_ready = !skid_valid_ff;

   // squares of the magnitudes
   assign mag_x    = mag(req_data.x_coord);
   assign mag_y    = mag(req_data.y_coord);
   assign mag_z    = mag(req_data.z_coord);
   assign sq_px_in = RADICAND_WIDTH'(mag_x) * RADICAND_WIDTH'(mag_x);
   assign sq_py_in = RADICAND_WIDTH'(mag_y) * RADICAND_WIDTH'(mag_y);
   assign sq_pz_in = RADICAND_WIDTH'(mag_z) * RADICAND_WIDTH'(mag_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (enable) begin
         sq_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sq_vec_ff <= req_data;
         sq_px_ff  <= sq_px_in;
         sq_py_ff  <= sq_py_in;
         sq_pz_ff  <= sq_pz_in;
      end
   end

   // sums of squares, roots start empty
   assign sum_xy = sq_px_ff + sq_py_ff;

   always_comb begin
      sum_item_in.rho.bits = sum_xy;
      sum_item_in.rho.root = '0;
      sum_item_in.rho.rem  = '0;
      sum_item_in.rad.bits = sum_xy + sq_pz_ff;
      sum_item_in.rad.root = '0;
      sum_item_in.rad.rem  = '0;
      sum_item_in.vec      = sq_vec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (enable) begin
         sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_item_ff <= sum_item_in;
      end
   end

   // square root cell row
   assign root_valid[0] = sum_valid_ff;
   assign root_item[0]  = sum_item_ff;

   for (genvar gi = 0; gi < ROOT_WIDTH; gi++) begin : g_root
      c2s_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (root_valid[gi]),
         .in_item   (root_item[gi]),
         .out_valid (root_valid[gi+1]),
         .out_item  (root_item[gi+1])
      );
   end

   // round roots to nearest
   assign root_last  = root_item[ROOT_WIDTH];
   assign rnd_rho_in = (root_last.rho.rem > {{(REM_WIDTH-ROOT_WIDTH){1'b0}}, root_last.rho.root})
                       ? root_last.rho.root + ROOT_WIDTH'(1) : root_last.rho.root;
   assign rnd_rad_in = (root_last.rad.rem > {{(REM_WIDTH-ROOT_WIDTH){1'b0}}, root_last.rad.root})
                       ? root_last.rad.root + ROOT_WIDTH'(1) : root_last.rad.root;

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else if (enable) begin
         rnd_valid_ff <= root_valid[ROOT_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rnd_rho_ff <= rnd_rho_in;
         rnd_rad_ff <= rnd_rad_in;
         rnd_vec_ff <= root_last.vec;
      end
   end

   // scale operands, fold the left half plane onto the right in both lanes
   always_comb begin
      pre_item_in.az.x  = {{EXT_BITS{rnd_vec_ff.x_coord[COORD_WIDTH-1]}},
                           rnd_vec_ff.x_coord, {GUARD_BITS{1'b0}}};
      pre_item_in.az.y  = {{EXT_BITS{rnd_vec_ff.y_coord[COORD_WIDTH-1]}},
                           rnd_vec_ff.y_coord, {GUARD_BITS{1'b0}}};
      pre_item_in.az.ang  = '0;
      pre_item_in.pol.x = {{EXT_BITS{rnd_vec_ff.z_coord[COORD_WIDTH-1]}},
                           rnd_vec_ff.z_coord, {GUARD_BITS{1'b0}}};
      pre_item_in.pol.y = {{EXT_BITS{1'b0}}, rnd_rho_ff, {GUARD_BITS{1'b0}}};
      pre_item_in.pol.ang = '0;
      if (rnd_vec_ff.x_coord[COORD_WIDTH-1]) begin
         pre_item_in.az.x   = -pre_item_in.az.x;
         pre_item_in.az.y   = -pre_item_in.az.y;
         pre_item_in.az.ang = rnd_vec_ff.y_coord[COORD_WIDTH-1] ? (-PI_Q60) : PI_Q60;
      end
      if (rnd_vec_ff.z_coord[COORD_WIDTH-1]) begin
         pre_item_in.pol.x   = -pre_item_in.pol.x;
         pre_item_in.pol.y   = -pre_item_in.pol.y;
         pre_item_in.pol.ang = PI_Q60;
      end
      pre_item_in.radius   = rnd_rad_ff;
      pre_item_in.az_zero  = (rnd_vec_ff.x_coord == '0) && (rnd_vec_ff.y_coord == '0);
      pre_item_in.all_zero = pre_item_in.az_zero && (rnd_vec_ff.z_coord == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (enable) begin
         pre_valid_ff <= rnd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pre_item_ff <= pre_item_in;
      end
   end

   // CORDIC cell row
   assign cordic_valid[0] = pre_valid_ff;
   assign cordic_item[0]  = pre_item_ff;

   for (genvar gc = 0; gc < CORDIC_STAGES; gc++) begin : g_cordic
      c2s_cordic_cell #(
         .STAGE_IDX (gc)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (cordic_valid[gc]),
         .in_item   (cordic_item[gc]),
         .out_valid (cordic_valid[gc+1]),
         .out_item  (cordic_item[gc+1])
      );
   end

   // round, clamp and apply the zero cases
   assign fin_item  = cordic_item[CORDIC_STAGES];
   assign fin_valid = cordic_valid[CORDIC_STAGES];

   always_comb begin
      fin_az  = to_out(fin_item.az.ang);
      fin_pol = to_out(fin_item.pol.ang);
      if (fin_az > PI_OUT) begin
         fin_az = PI_OUT;
      end else if (fin_az < -PI_OUT) begin
         fin_az = -PI_OUT;
      end
      if (fin_pol < 0) begin
         fin_pol = '0;
      end else if (fin_pol > PI_OUT) begin
         fin_pol = PI_OUT;
      end
      if (fin_item.az_zero) begin
         fin_az = '0;
      end
      if (fin_item.all_zero) begin
         fin_pol = '0;
      end
      fin_rsp.radius      = fin_item.radius;
      fin_rsp.azimuth     = fin_az[AZIMUTH_WIDTH-1:0];
      fin_rsp.polar_angle = fin_pol[POLAR_WIDTH-1:0];
   end

   // output register with one skid beat
   always_comb begin
      out_take      = rsp_valid_ff && rsp_ready;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (fin_valid) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = fin_rsp;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = fin_rsp;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
